// ===== design/tmed_pkg.sv =====
// ----------------------------------------------------------------------------
// tmed_pkg: shared types and helpers for the trail map decay and blur core
// Map geometry, field widths, codes and the small arithmetic helpers used
// by the interfaces and the core.
// ----------------------------------------------------------------------------
`default_nettype none

package tmed_pkg;

	localparam int WIDTH  = 256;
	localparam int HEIGHT = 256;
	localparam int MARGIN = 1;

	localparam int DEPTH  = HEIGHT * WIDTH;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int ROW_W  = $clog2(HEIGHT);
	localparam int COL_W  = $clog2(WIDTH);
	localparam int ROW_HI = HEIGHT - MARGIN;
	localparam int COL_HI = WIDTH - MARGIN;

	localparam int PIX_W   = 24;
	localparam int CHAN_W  = 8;
	localparam int SUM_W   = 12;
	localparam int OP_W    = 2;
	localparam int COORD_W = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 24;

	// floor(s / 9) as (s * ceil(2^16 / 9)) >> 16, exact for s below 2304
	localparam int DIV9_SHIFT = 16;
	localparam int DIV9_RECIP = ((1 << DIV9_SHIFT) + 8) / 9;
	localparam int PROD_W     = SUM_W + 13;

	localparam logic [PIX_W-1:0]  PIX_MAX       = 24'hFF_FFFF;
	localparam logic [CHAN_W-1:0] DECAY_RESET   = 8'd1;
	localparam logic [PIX_W-1:0]  DEPOSIT_RESET = 24'hFF_FFFF;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [ROW_W-1:0]  row_t;
	typedef logic [COL_W-1:0]  col_t;
	typedef logic [PIX_W-1:0]  pix_t;
	typedef logic [SUM_W-1:0]  sum_t;

	typedef enum logic [OP_W-1:0] {
		OP_DEPOSIT = 2'd0,
		OP_READ    = 2'd1,
		OP_PASS    = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DECAY   = 1'b0,
		REG_DEPOSIT = 1'b1
	} reg_idx_t;

	function automatic addr_t pix_addr(logic [31:0] r, logic [31:0] c);
		logic [31:0] a;
		a = r * 32'(WIDTH) + c;
		return a[ADDR_W-1:0];
	endfunction

	function automatic row_t clamp_row(row_t r, logic [1:0] off);
		logic [ROW_W:0] t;
		t = {1'b0, r} + (ROW_W+1)'(off);
		if (t == '0) begin
			return '0;
		end
		t = t - (ROW_W+1)'(1);
		if (t > (ROW_W+1)'(ROW_HI)) begin
			t = (ROW_W+1)'(ROW_HI);
		end
		return t[ROW_W-1:0];
	endfunction

	function automatic col_t clamp_col(col_t c, logic [1:0] off);
		logic [COL_W:0] t;
		t = {1'b0, c} + (COL_W+1)'(off);
		if (t == '0) begin
			return '0;
		end
		t = t - (COL_W+1)'(1);
		if (t > (COL_W+1)'(COL_HI)) begin
			t = (COL_W+1)'(COL_HI);
		end
		return t[COL_W-1:0];
	endfunction

	function automatic logic [CHAN_W-1:0] div9(sum_t s);
		logic [PROD_W-1:0] p;
		p = PROD_W'(s) * PROD_W'(DIV9_RECIP);
		return p[DIV9_SHIFT+CHAN_W-1:DIV9_SHIFT];
	endfunction

endpackage

`default_nettype wire

// ===== design/tmed_ifs.sv =====
// ----------------------------------------------------------------------------
// tmed channels: command, response and register write interfaces
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface tmed_cmd_if;
	logic                             valid;
	logic                             ready;
	logic [tmed_pkg::OP_W-1:0]        operation;
	logic [tmed_pkg::COORD_W-1:0]     row;
	logic [tmed_pkg::COORD_W-1:0]     col;

	modport source (output valid, output operation, output row, output col, input ready);
	modport sink   (input valid, input operation, input row, input col, output ready);
endinterface

interface tmed_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [tmed_pkg::PIX_W-1:0]   pixel;

	modport source (output valid, output pixel, input ready);
	modport sink   (input valid, input pixel, output ready);
endinterface

interface tmed_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [tmed_pkg::CFG_IDX_W-1:0]   index;
	logic [tmed_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/trail_map_evaporate_diffuse_core.sv =====
// ----------------------------------------------------------------------------
// trail_map_evaporate_diffuse_core: trail map with decay and 3x3 box blur
// Packed RGB map in one RAM; deposit, read and an in-place raster pass.
//
//   channel  role    payload                   moves when
//   cmd      sink    operation, row, col       cmd.valid & cmd.ready
//   rsp      source  pixel                     rsp.valid & rsp.ready
//   cfg      sink    index, data               cfg.valid & cfg.ready
//
// after reset all HEIGHT*WIDTH map RAM words are swept to zero, cmd held off
// deposit and op 3 finish in the cycle they are accepted; a read goes via the
// RAM read register to the result register; a pass runs in raster order, paced
// by the single RAM read port: one centre read, nine neighbour reads, two writes
// a read waits in place while rsp is stalled; cfg is always ready
// ----------------------------------------------------------------------------
`default_nettype none

module trail_map_evaporate_diffuse_core (
	input  wire logic      clk,
	input  wire logic      arst_n,
	tmed_cmd_if.sink       cmd,
	tmed_rsp_if.source     rsp,
	tmed_cfg_if.sink       cfg
);

	typedef enum logic [7:0] {
		S_CLEAR = 8'b0000_0001,
		S_IDLE  = 8'b0000_0010,
		S_READ  = 8'b0000_0100,
		S_FETCH = 8'b0000_1000,
		S_DECAY = 8'b0001_0000,
		S_NBR   = 8'b0010_0000,
		S_DRAIN = 8'b0100_0000,
		S_BLUR  = 8'b1000_0000
	} state_t;

	state_t                         state_q;
	tmed_pkg::addr_t                clr_q;
	tmed_pkg::row_t                 pr_q;
	tmed_pkg::col_t                 pc_q;
	logic [1:0]                     nb_r_q;
	logic [1:0]                     nb_c_q;
	logic                           nbv_s1;
	tmed_pkg::sum_t                 acc_r_q;
	tmed_pkg::sum_t                 acc_g_q;
	tmed_pkg::sum_t                 acc_b_q;
	logic                           outside_q;
	logic                           rsp_valid_q;
	tmed_pkg::pix_t                 pixel_q;
	logic [tmed_pkg::CHAN_W-1:0]    decay_q;
	tmed_pkg::pix_t                 deposit_q;

	logic                           accept;
	logic                           on_map;
	logic                           slot_free;
	logic                           nb_last;
	tmed_pkg::addr_t                cmd_addr;
	tmed_pkg::addr_t                ctr_addr;
	tmed_pkg::addr_t                nbr_addr;
	logic [tmed_pkg::PIX_W:0]       diff;
	tmed_pkg::pix_t                 decayed;
	tmed_pkg::pix_t                 blurred;

	logic                           wr_en;
	tmed_pkg::addr_t                wr_addr;
	tmed_pkg::pix_t                 wr_data;
	logic                           rd_en;
	tmed_pkg::addr_t                rd_addr;
	tmed_pkg::pix_t                 rd_data;

	tmed_ram #(
		.DATA_W (tmed_pkg::PIX_W),
		.DEPTH  (tmed_pkg::DEPTH)
	) u_map (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign cmd.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_valid_q;
	assign rsp.pixel = pixel_q;

	assign accept    = cmd.valid && cmd.ready;
	assign on_map    = (32'(cmd.row) < 32'(tmed_pkg::HEIGHT)) &&
	                   (32'(cmd.col) < 32'(tmed_pkg::WIDTH));
	assign slot_free = !rsp_valid_q || rsp.ready;
	assign nb_last   = (nb_r_q == 2'd2) && (nb_c_q == 2'd2);

	assign cmd_addr = tmed_pkg::pix_addr(32'(cmd.row), 32'(cmd.col));
	assign ctr_addr = tmed_pkg::pix_addr(32'(pr_q), 32'(pc_q));
	assign nbr_addr = tmed_pkg::pix_addr(32'(tmed_pkg::clamp_row(pr_q, nb_r_q)),
	                                     32'(tmed_pkg::clamp_col(pc_q, nb_c_q)));

	// one 24-bit subtract with borrow; borrow or all ones gives zero
	assign diff    = {1'b0, rd_data} - {1'b0, decay_q, decay_q, decay_q};
	assign decayed = (diff[tmed_pkg::PIX_W] || (diff[tmed_pkg::PIX_W-1:0] == tmed_pkg::PIX_MAX))
	                 ? '0 : diff[tmed_pkg::PIX_W-1:0];
	assign blurred = {tmed_pkg::div9(acc_r_q), tmed_pkg::div9(acc_g_q),
	                  tmed_pkg::div9(acc_b_q)};

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ctr_addr;
		wr_data = '0;
		rd_en   = 1'b0;
		rd_addr = ctr_addr;
		case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
			end
			S_IDLE: begin
				if (accept) begin
					case (tmed_pkg::op_t'(cmd.operation))
						tmed_pkg::OP_DEPOSIT: begin
							wr_en   = on_map;
							wr_addr = cmd_addr;
							wr_data = deposit_q;
						end
						tmed_pkg::OP_READ: begin
							rd_en   = on_map;
							rd_addr = cmd_addr;
						end
						default: begin
						end
					endcase
				end
			end
			S_FETCH: begin
				rd_en = 1'b1;
			end
			S_DECAY: begin
				wr_en   = 1'b1;
				wr_data = decayed;
			end
			S_NBR: begin
				rd_en   = 1'b1;
				rd_addr = nbr_addr;
			end
			S_BLUR: begin
				wr_en   = 1'b1;
				wr_data = blurred;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			pr_q        <= '0;
			pc_q        <= '0;
			nb_r_q      <= '0;
			nb_c_q      <= '0;
			nbv_s1      <= 1'b0;
			acc_r_q     <= '0;
			acc_g_q     <= '0;
			acc_b_q     <= '0;
			outside_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
			pixel_q     <= '0;
			decay_q     <= tmed_pkg::DECAY_RESET;
			deposit_q   <= tmed_pkg::DEPOSIT_RESET;
		end else begin
			if (cfg.valid) begin
				case (tmed_pkg::reg_idx_t'(cfg.index))
					tmed_pkg::REG_DECAY:   decay_q   <= cfg.data[tmed_pkg::CHAN_W-1:0];
					tmed_pkg::REG_DEPOSIT: deposit_q <= cfg.data[tmed_pkg::PIX_W-1:0];
					default: begin
					end
				endcase
			end

			// neighbour data lands in the cycle after its read
			nbv_s1 <= (state_q == S_NBR);
			if (state_q == S_DECAY) begin
				acc_r_q <= '0;
				acc_g_q <= '0;
				acc_b_q <= '0;
			end else if (nbv_s1) begin
				acc_r_q <= acc_r_q + tmed_pkg::SUM_W'(rd_data[23:16]);
				acc_g_q <= acc_g_q + tmed_pkg::SUM_W'(rd_data[15:8]);
				acc_b_q <= acc_b_q + tmed_pkg::SUM_W'(rd_data[7:0]);
			end

			if ((state_q == S_READ) && slot_free) begin
				rsp_valid_q <= 1'b1;
				pixel_q     <= outside_q ? '0 : rd_data;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + tmed_pkg::ADDR_W'(1);
					if (clr_q == tmed_pkg::ADDR_W'(tmed_pkg::DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						case (tmed_pkg::op_t'(cmd.operation))
							tmed_pkg::OP_READ: begin
								outside_q <= !on_map;
								state_q   <= S_READ;
							end
							tmed_pkg::OP_PASS: begin
								pr_q    <= '0;
								pc_q    <= '0;
								state_q <= S_FETCH;
							end
							default: begin
							end
						endcase
					end
				end
				S_READ: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				S_FETCH: begin
					state_q <= S_DECAY;
				end
				S_DECAY: begin
					nb_r_q  <= '0;
					nb_c_q  <= '0;
					state_q <= S_NBR;
				end
				S_NBR: begin
					if (nb_c_q == 2'd2) begin
						nb_c_q <= '0;
						nb_r_q <= nb_r_q + 2'd1;
					end else begin
						nb_c_q <= nb_c_q + 2'd1;
					end
					if (nb_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_BLUR;
				end
				S_BLUR: begin
					state_q <= S_FETCH;
					if (pc_q == tmed_pkg::COL_W'(tmed_pkg::WIDTH - 1)) begin
						pc_q <= '0;
						if (pr_q == tmed_pkg::ROW_W'(tmed_pkg::HEIGHT - 1)) begin
							pr_q    <= '0;
							state_q <= S_IDLE;
						end else begin
							pr_q <= pr_q + tmed_pkg::ROW_W'(1);
						end
					end else begin
						pc_q <= pc_q + tmed_pkg::COL_W'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== design/tmed_ram.sv =====
// ----------------------------------------------------------------------------
// tmed_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tmed_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [DATA_W-1:0]        wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [DATA_W-1:0]        rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire
